FILE: rtl/cvtg_pkg.sv
// Shared types, register map and reset values for the composite video timing generator.
package cvtg_pkg;

	localparam logic [11:0] RST_LINE_LENGTH       = 12'd3000;
	localparam logic [9:0]  RST_FRONT_PORCH       = 10'd71;
	localparam logic [9:0]  RST_HSYNC_WIDTH       = 10'd222;
	localparam logic [9:0]  RST_BACK_PORCH        = 10'd222;
	localparam logic [11:0] RST_VSYNC_LOW_WIDTH   = 12'd2811;
	localparam logic [8:0]  RST_TOTAL_LINES       = 9'd262;
	localparam logic [8:0]  RST_VSYNC_FIRST_LINE  = 9'd6;
	localparam logic [8:0]  RST_ACTIVE_FIRST_LINE = 9'd18;

	localparam int PADDR_W = 5;

	typedef enum logic [2:0] {
		REG_LINE_LENGTH       = 3'd0,
		REG_FRONT_PORCH       = 3'd1,
		REG_HSYNC_WIDTH       = 3'd2,
		REG_BACK_PORCH        = 3'd3,
		REG_VSYNC_LOW_WIDTH   = 3'd4,
		REG_TOTAL_LINES       = 3'd5,
		REG_VSYNC_FIRST_LINE  = 3'd6,
		REG_ACTIVE_FIRST_LINE = 3'd7
	} reg_idx_t;

	typedef enum logic {
		FUNC_TICK  = 1'b0,
		FUNC_WRITE = 1'b1
	} func_t;

	typedef struct packed {
		logic        func;
		logic [13:0] fb_addr;
		logic [7:0]  fb_data;
	} in_word_t;

	typedef struct packed {
		logic        sync_level;
		logic        video_white;
		logic [8:0]  line_number;
		logic [11:0] column;
	} out_word_t;

	typedef struct packed {
		logic [11:0] line_length;
		logic [9:0]  front_porch;
		logic [9:0]  hsync_width;
		logic [9:0]  back_porch;
		logic [11:0] vsync_low_width;
		logic [8:0]  total_lines;
		logic [8:0]  vsync_first_line;
		logic [8:0]  active_first_line;
	} cfg_t;

	typedef struct packed {
		logic        tick;
		logic        sync_level;
		logic        pix_en;
		logic [2:0]  bit_sel;
		logic [8:0]  line_number;
		logic [11:0] column;
	} s0_info_t;

endpackage

FILE: rtl/cvtg_regs.sv
// APB configuration registers of the timing generator.
module cvtg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cvtg_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	output cvtg_pkg::cfg_t              cfg
);
	import cvtg_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_length       <= RST_LINE_LENGTH;
			cfg_q.front_porch       <= RST_FRONT_PORCH;
			cfg_q.hsync_width       <= RST_HSYNC_WIDTH;
			cfg_q.back_porch        <= RST_BACK_PORCH;
			cfg_q.vsync_low_width   <= RST_VSYNC_LOW_WIDTH;
			cfg_q.total_lines       <= RST_TOTAL_LINES;
			cfg_q.vsync_first_line  <= RST_VSYNC_FIRST_LINE;
			cfg_q.active_first_line <= RST_ACTIVE_FIRST_LINE;
		end else if (wr) begin
			case (idx)
				REG_LINE_LENGTH:       cfg_q.line_length       <= pwdata[11:0];
				REG_FRONT_PORCH:       cfg_q.front_porch       <= pwdata[9:0];
				REG_HSYNC_WIDTH:       cfg_q.hsync_width       <= pwdata[9:0];
				REG_BACK_PORCH:        cfg_q.back_porch        <= pwdata[9:0];
				REG_VSYNC_LOW_WIDTH:   cfg_q.vsync_low_width   <= pwdata[11:0];
				REG_TOTAL_LINES:       cfg_q.total_lines       <= pwdata[8:0];
				REG_VSYNC_FIRST_LINE:  cfg_q.vsync_first_line  <= pwdata[8:0];
				REG_ACTIVE_FIRST_LINE: cfg_q.active_first_line <= pwdata[8:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_LINE_LENGTH:       prdata = {20'd0, cfg_q.line_length};
			REG_FRONT_PORCH:       prdata = {22'd0, cfg_q.front_porch};
			REG_HSYNC_WIDTH:       prdata = {22'd0, cfg_q.hsync_width};
			REG_BACK_PORCH:        prdata = {22'd0, cfg_q.back_porch};
			REG_VSYNC_LOW_WIDTH:   prdata = {20'd0, cfg_q.vsync_low_width};
			REG_TOTAL_LINES:       prdata = {23'd0, cfg_q.total_lines};
			REG_VSYNC_FIRST_LINE:  prdata = {23'd0, cfg_q.vsync_first_line};
			REG_ACTIVE_FIRST_LINE: prdata = {23'd0, cfg_q.active_first_line};
			default:               prdata = 32'd0;
		endcase
	end

endmodule

FILE: rtl/cvtg_fbram.sv
// Single-port frame store with registered read data.
module cvtg_fbram #(
	parameter int DEPTH = 10240,
	parameter int AW    = 14
) (
	input  logic          clk,
	input  logic          we,
	input  logic          re,
	input  logic [AW-1:0] addr,
	input  logic [7:0]    wdata,
	output logic [7:0]    rdata
);

	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;

	assign rdata = rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		if (re)
			rdata_q <= mem[addr];
	end

endmodule

FILE: rtl/cvtg_timing.sv
// Position counters, sync decode and frame store address generation.
module cvtg_timing #(
	parameter int PIXELS_PER_LINE = 320,
	parameter int BYTES_PER_ROW   = 40,
	parameter int FB_ROWS         = 256,
	parameter int VSYNC_LINES     = 6,
	parameter int STORE_BYTES     = 10240,
	parameter int AW              = 14
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  cvtg_pkg::in_word_t   in_word,
	input  cvtg_pkg::cfg_t       cfg,
	output cvtg_pkg::s0_info_t   info,
	output logic                 ram_we,
	output logic                 ram_re,
	output logic [AW-1:0]        ram_addr,
	output logic [7:0]           ram_wdata
);
	import cvtg_pkg::*;

	logic [11:0] h_q;
	logic [8:0]  ln_q;
	logic        is_tick;
	logic [8:0]  vs_diff;
	logic        vs_line;
	logic [11:0] hs_end;
	logic [11:0] nrm_start;
	logic [11:0] pix_start;
	logic        active;
	logic [8:0]  row;
	logic [11:0] pix;
	logic        pix_ok;
	logic [AW-1:0] rd_addr;
	logic        wr_ok;
	logic [12:0] h_inc;
	logic [9:0]  ln_inc;

	assign is_tick   = (in_word.func == FUNC_TICK);
	assign vs_diff   = ln_q - cfg.vsync_first_line;
	assign vs_line   = (ln_q >= cfg.vsync_first_line) && (vs_diff < 9'(VSYNC_LINES));
	assign hs_end    = 12'(cfg.front_porch) + 12'(cfg.hsync_width);
	assign nrm_start = hs_end + 12'(cfg.back_porch);
	assign pix_start = vs_line ? cfg.vsync_low_width : nrm_start;
	assign active    = (ln_q >= cfg.active_first_line) && (h_q >= pix_start);
	assign row       = ln_q - cfg.active_first_line;
	assign pix       = h_q - pix_start;
	assign pix_ok    = active && ({1'b0, row} < 10'(FB_ROWS))
		&& ({1'b0, pix} < 13'(PIXELS_PER_LINE)) && (pix[11:3] < 9'(BYTES_PER_ROW));
	assign rd_addr   = AW'(row) * AW'(BYTES_PER_ROW) + AW'(pix[11:3]);
	assign wr_ok     = 32'(in_word.fb_addr) < 32'(STORE_BYTES);

	assign info.tick        = accept && is_tick;
	assign info.sync_level  = vs_line ? !(h_q < cfg.vsync_low_width)
		: !((h_q >= 12'(cfg.front_porch)) && (h_q < hs_end));
	assign info.pix_en      = pix_ok;
	assign info.bit_sel     = pix[2:0];
	assign info.line_number = ln_q;
	assign info.column      = h_q;

	assign ram_we    = accept && !is_tick && wr_ok;
	assign ram_re    = accept && is_tick;
	assign ram_addr  = is_tick ? rd_addr : AW'(in_word.fb_addr);
	assign ram_wdata = in_word.fb_data;

	assign h_inc  = {1'b0, h_q} + 13'd1;
	assign ln_inc = {1'b0, ln_q} + 10'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q  <= '0;
			ln_q <= '0;
		end else if (accept && is_tick) begin
			if (h_inc >= {1'b0, cfg.line_length}) begin
				h_q <= '0;
				if (ln_inc >= {1'b0, cfg.total_lines})
					ln_q <= '0;
				else
					ln_q <= ln_inc[8:0];
			end else begin
				h_q <= h_inc[11:0];
			end
		end
	end

endmodule

FILE: rtl/composite_video_timing_generator.sv
// Top level of the composite video timing generator.
//
// Input channel in_valid/in_ready/in_word: a word with func tick advances the
// raster by one pixel and yields one output word; a word with func write
// stores fb_data into the frame store at fb_addr and yields nothing.
// Output channel out_valid/out_ready/out_word: sync level, video level, line
// and column of each tick, in tick order.
// Each accepted tick passes the read stage, where the frame store is read, and
// then the output register before it is offered on out_word.
// Throughput: one word per clock while in_ready is high, ticks and writes
// alike; the single frame store port is used by at most one word per cycle.
// When out_ready is held low, one result waits in the output register and one
// in the read stage; in_ready drops only when both are full.
// Reset clears the counters to line 0 column 0 and loads the default timing
// registers. The frame store is not cleared: write every byte that active
// lines can show before ticking through them. Configuration is over APB at
// byte address 4*index; the user must write it only while idle (unchecked).
module composite_video_timing_generator #(
	parameter int PIXELS_PER_LINE = 320,
	parameter int BYTES_PER_ROW   = 40,
	parameter int FB_ROWS         = 256,
	parameter int VSYNC_LINES     = 6
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  cvtg_pkg::in_word_t           in_word,
	output logic                         out_valid,
	input  logic                         out_ready,
	output cvtg_pkg::out_word_t          out_word,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [cvtg_pkg::PADDR_W-1:0] paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import cvtg_pkg::*;

	localparam int STORE_BYTES = FB_ROWS * BYTES_PER_ROW;
	localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;

	cfg_t       cfg;
	s0_info_t   info;
	logic       accept;
	logic       ram_we;
	logic       ram_re;
	logic [AW-1:0] ram_addr;
	logic [7:0] ram_wdata;
	logic [7:0] ram_rdata;

	logic       s1_valid_q;
	logic       s1_sync_s1;
	logic       s1_pix_en_s1;
	logic [2:0] s1_bit_s1;
	logic [8:0] s1_line_s1;
	logic [11:0] s1_col_s1;
	logic       s1_move;
	logic       out_valid_q;
	out_word_t  out_q;

	assign s1_move  = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	cvtg_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cvtg_timing #(
		.PIXELS_PER_LINE (PIXELS_PER_LINE),
		.BYTES_PER_ROW   (BYTES_PER_ROW),
		.FB_ROWS         (FB_ROWS),
		.VSYNC_LINES     (VSYNC_LINES),
		.STORE_BYTES     (STORE_BYTES),
		.AW              (AW)
	) u_timing (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.in_word   (in_word),
		.cfg       (cfg),
		.info      (info),
		.ram_we    (ram_we),
		.ram_re    (ram_re),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata)
	);

	cvtg_fbram #(
		.DEPTH (STORE_BYTES),
		.AW    (AW)
	) u_fbram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// read stage: frame store data lands alongside these
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_q <= 1'b0;
		else if (in_ready)
			s1_valid_q <= info.tick;
	end

	always_ff @(posedge clk) begin
		if (info.tick) begin
			s1_sync_s1   <= info.sync_level;
			s1_pix_en_s1 <= info.pix_en;
			s1_bit_s1    <= info.bit_sel;
			s1_line_s1   <= info.line_number;
			s1_col_s1    <= info.column;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (s1_move)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_q.sync_level  <= s1_sync_s1;
			out_q.video_white <= s1_pix_en_s1 && ram_rdata[3'd7 - s1_bit_s1];
			out_q.line_number <= s1_line_s1;
			out_q.column      <= s1_col_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (in_word.func == FUNC_WRITE) |=> !s1_valid_q)
		else $error("write word entered read stage");

	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_move |=> s1_valid_q && $stable(s1_col_s1) && $stable(s1_line_s1))
		else $error("stalled read stage lost its word");

	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> s1_valid_q && out_valid_q && !out_ready)
		else $error("input stalled without a full pipeline");

	a_tick_reads: assert property (@(posedge clk) disable iff (!arst_n)
		ram_re |-> !ram_we && accept)
		else $error("frame store port used twice");

endmodule
